// ===== hdl/gc_pkg.sv =====
// ----------------------------------------------------------------------------
// gc_pkg
// Shared types, codes and constants of the gesture classifier.
// ----------------------------------------------------------------------------
package gc_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int TIME_W         = 48;
   localparam int GAP_W          = 24;
   localparam int SQ_W           = 31;  // one square of a 16-bit sample
   localparam int MAG_W          = 32;  // sum of three squares
   localparam int LEVEL_W        = 16;
   localparam int TILT_W         = 15;
   localparam int GESTURE_W      = 4;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 5;
   localparam int REG_INDEX_W    = 3;

   localparam int SHAKE_MIN_SAMPLES_DEFAULT = 4;
   localparam int QUEUE_DEPTH_DEFAULT       = 2;

   localparam logic [LEVEL_W-1:0] FREEFALL_RESET = 16'd200;
   localparam logic [LEVEL_W-1:0] TAP_RESET      = 16'd1200;
   localparam logic [LEVEL_W-1:0] SHAKE_RESET    = 16'd800;
   localparam logic [TILT_W-1:0]  TILT_RESET     = 15'd300;
   localparam logic [LEVEL_W-1:0] FLIP_RESET     = 16'd800;
   localparam logic [GAP_W-1:0]   GAP_MIN_RESET  = 24'd100000;
   localparam logic [GAP_W-1:0]   GAP_MAX_RESET  = 24'd500000;

   localparam logic [MAG_W-1:0] FREEFALL_SQ_RESET = 32'(200 * 200);
   localparam logic [MAG_W-1:0] TAP_SQ_RESET      = 32'(1200 * 1200);
   localparam logic [MAG_W-1:0] SHAKE_SQ_RESET    = 32'(800 * 800);

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_FREEFALL_LEVEL = 3'd0,
      REG_TAP_LEVEL      = 3'd1,
      REG_SHAKE_LEVEL    = 3'd2,
      REG_TILT_LEVEL     = 3'd3,
      REG_FLIP_LEVEL     = 3'd4,
      REG_TAP_GAP_MIN    = 3'd5,
      REG_TAP_GAP_MAX    = 3'd6
   } reg_index_type;

   typedef enum logic [GESTURE_W-1:0] {
      GEST_NONE    = 4'd0,
      GEST_FALL    = 4'd1,
      GEST_DOUBLE  = 4'd2,
      GEST_SHAKE   = 4'd3,
      GEST_RIGHT   = 4'd4,
      GEST_LEFT    = 4'd5,
      GEST_FORWARD = 4'd6,
      GEST_BACK    = 4'd7,
      GEST_FLIP    = 4'd8
   } gesture_type;

   // settings as the back end uses them
   typedef struct packed {
      logic [MAG_W-1:0]   freefall_sq;
      logic [MAG_W-1:0]   tap_sq;
      logic [MAG_W-1:0]   shake_sq;
      logic [TILT_W-1:0]  shake_half;
      logic [TILT_W-1:0]  tilt_level;
      logic [LEVEL_W-1:0] flip_level;
      logic [GAP_W-1:0]   gap_min;
      logic [GAP_W-1:0]   gap_max;
   } cfg_type;

   // one prepared sample, as it waits in the queue
   typedef struct packed {
      logic [SQ_W-1:0]     sq_x;
      logic [SQ_W-1:0]     sq_y;
      logic [SQ_W-1:0]     sq_z;
      logic [SAMPLE_W-1:0] x;
      logic [SAMPLE_W-1:0] y;
      logic [SAMPLE_W-1:0] z;
      logic [TIME_W-1:0]   time_us;
      logic [SAMPLE_W-1:0] x_jump;
      logic                shake_armed;
   } sample_type;

endpackage

// ===== hdl/gc_csr.sv =====
// ----------------------------------------------------------------------------
// gc_csr
// Register file on the APB-style port; keeps squared magnitude thresholds.
// ----------------------------------------------------------------------------
module gc_csr
   import gc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [LEVEL_W-1:0] freefall_ff;
   logic [LEVEL_W-1:0] tap_ff;
   logic [LEVEL_W-1:0] shake_ff;
   logic [TILT_W-1:0]  tilt_ff;
   logic [LEVEL_W-1:0] flip_ff;
   logic [GAP_W-1:0]   gap_min_ff;
   logic [GAP_W-1:0]   gap_max_ff;
   logic [MAG_W-1:0]   freefall_sq_ff;
   logic [MAG_W-1:0]   tap_sq_ff;
   logic [MAG_W-1:0]   shake_sq_ff;
   logic               write_en;
   reg_index_type      index;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;
   assign index    = reg_index_type'(paddr[REG_INDEX_W+1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         freefall_ff <= FREEFALL_RESET;
         tap_ff      <= TAP_RESET;
         shake_ff    <= SHAKE_RESET;
         tilt_ff     <= TILT_RESET;
         flip_ff     <= FLIP_RESET;
         gap_min_ff  <= GAP_MIN_RESET;
         gap_max_ff  <= GAP_MAX_RESET;
      end else if (write_en) begin
         case (index)
            REG_FREEFALL_LEVEL: freefall_ff <= pwdata[LEVEL_W-1:0];
            REG_TAP_LEVEL:      tap_ff      <= pwdata[LEVEL_W-1:0];
            REG_SHAKE_LEVEL:    shake_ff    <= pwdata[LEVEL_W-1:0];
            REG_TILT_LEVEL:     tilt_ff     <= pwdata[TILT_W-1:0];
            REG_FLIP_LEVEL:     flip_ff     <= pwdata[LEVEL_W-1:0];
            REG_TAP_GAP_MIN:    gap_min_ff  <= pwdata[GAP_W-1:0];
            REG_TAP_GAP_MAX:    gap_max_ff  <= pwdata[GAP_W-1:0];
            default: ;
         endcase
      end
   end

   // squares follow the levels in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         freefall_sq_ff <= FREEFALL_SQ_RESET;
         tap_sq_ff      <= TAP_SQ_RESET;
         shake_sq_ff    <= SHAKE_SQ_RESET;
      end else begin
         freefall_sq_ff <= MAG_W'(freefall_ff) * MAG_W'(freefall_ff);
         tap_sq_ff      <= MAG_W'(tap_ff) * MAG_W'(tap_ff);
         shake_sq_ff    <= MAG_W'(shake_ff) * MAG_W'(shake_ff);
      end
   end

   always_comb begin
      prdata = '0;
      case (index)
         REG_FREEFALL_LEVEL: prdata = CSR_DATA_W'(freefall_ff);
         REG_TAP_LEVEL:      prdata = CSR_DATA_W'(tap_ff);
         REG_SHAKE_LEVEL:    prdata = CSR_DATA_W'(shake_ff);
         REG_TILT_LEVEL:     prdata = CSR_DATA_W'(tilt_ff);
         REG_FLIP_LEVEL:     prdata = CSR_DATA_W'(flip_ff);
         REG_TAP_GAP_MIN:    prdata = CSR_DATA_W'(gap_min_ff);
         REG_TAP_GAP_MAX:    prdata = CSR_DATA_W'(gap_max_ff);
         default:            prdata = '0;
      endcase
   end

   assign cfg.freefall_sq = freefall_sq_ff;
   assign cfg.tap_sq      = tap_sq_ff;
   assign cfg.shake_sq    = shake_sq_ff;
   assign cfg.shake_half  = shake_ff[LEVEL_W-1:1];
   assign cfg.tilt_level  = tilt_ff;
   assign cfg.flip_level  = flip_ff;
   assign cfg.gap_min     = gap_min_ff;
   assign cfg.gap_max     = gap_max_ff;

endmodule

// ===== hdl/gc_front.sv =====
// ----------------------------------------------------------------------------
// gc_front
// Takes samples in, squares the axes and tracks the previous x and the
// sample count that only depend on arrival order.
// ----------------------------------------------------------------------------
module gc_front
   import gc_pkg::*;
#(
   parameter int SHAKE_MIN_SAMPLES = SHAKE_MIN_SAMPLES_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_accel_x,
   input  logic [SAMPLE_W-1:0] req_accel_y,
   input  logic [SAMPLE_W-1:0] req_accel_z,
   input  logic [TIME_W-1:0]   req_time_us,
   output logic                push_valid,
   input  logic                push_ready,
   output sample_type          push_data
);

   localparam int SEEN_W = $clog2(SHAKE_MIN_SAMPLES + 1);
   localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(SHAKE_MIN_SAMPLES);

   logic [SAMPLE_W-1:0] prev_x_ff;
   logic [SAMPLE_W-1:0] prev_x_in;
   logic [SEEN_W-1:0]   seen_ff;
   logic [SEEN_W-1:0]   seen_in;
   logic                accept;
   logic signed [MAG_W-1:0]    prod_x;
   logic signed [MAG_W-1:0]    prod_y;
   logic signed [MAG_W-1:0]    prod_z;
   logic signed [SAMPLE_W:0]   diff_x;
   logic signed [SAMPLE_W:0]   abs_x;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   assign prod_x = MAG_W'($signed(req_accel_x)) * MAG_W'($signed(req_accel_x));
   assign prod_y = MAG_W'($signed(req_accel_y)) * MAG_W'($signed(req_accel_y));
   assign prod_z = MAG_W'($signed(req_accel_z)) * MAG_W'($signed(req_accel_z));

   assign diff_x = (SAMPLE_W+1)'($signed(req_accel_x)) - (SAMPLE_W+1)'($signed(prev_x_ff));
   assign abs_x  = diff_x[SAMPLE_W] ? -diff_x : diff_x;

   // count saturates; this sample is included
   assign seen_in   = (seen_ff < SEEN_MAX) ? seen_ff + 1'b1 : seen_ff;
   assign prev_x_in = req_accel_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         prev_x_ff <= '0;
      end else if (accept) begin
         seen_ff   <= seen_in;
         prev_x_ff <= prev_x_in;
      end
   end

   assign push_data.sq_x        = prod_x[SQ_W-1:0];
   assign push_data.sq_y        = prod_y[SQ_W-1:0];
   assign push_data.sq_z        = prod_z[SQ_W-1:0];
   assign push_data.x           = req_accel_x;
   assign push_data.y           = req_accel_y;
   assign push_data.z           = req_accel_z;
   assign push_data.time_us     = req_time_us;
   assign push_data.x_jump      = abs_x[SAMPLE_W-1:0];
   assign push_data.shake_armed = (seen_in >= SEEN_MAX);

endmodule

// ===== hdl/gc_queue.sv =====
// ----------------------------------------------------------------------------
// gc_queue
// Short register FIFO of prepared samples between front and back.
// ----------------------------------------------------------------------------
module gc_queue
   import gc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  sample_type push_data,
   output logic       pop_valid,
   input  logic       pop_ready,
   output sample_type pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   sample_type       slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/gc_back.sv =====
// ----------------------------------------------------------------------------
// gc_back
// Classifies one prepared sample per cycle unless the output is stalled,
// keeps the pending-tap state and holds the gesture in the output register.
// ----------------------------------------------------------------------------
module gc_back
   import gc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  sample_type           pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [GESTURE_W-1:0] rsp_gesture
);

   logic [TIME_W-1:0] tap_time_ff;
   logic [TIME_W-1:0] tap_time_in;
   logic              tap_waiting_ff;
   logic              tap_waiting_in;
   logic              rsp_valid_ff;
   gesture_type       gesture_ff;
   gesture_type       gesture_in;
   logic              pop;

   logic [MAG_W-1:0]         mag2;
   logic                     is_fall;
   logic                     is_loud;
   logic [TIME_W:0]          gap;
   logic                     in_window;
   logic                     is_double;
   logic                     is_shake;
   logic signed [SAMPLE_W:0] x_ext;
   logic signed [SAMPLE_W:0] y_ext;
   logic signed [SAMPLE_W:0] z_ext;
   logic signed [SAMPLE_W:0] tilt_pos;
   logic signed [SAMPLE_W:0] tilt_neg;
   logic signed [SAMPLE_W:0] flip_neg;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;

   assign mag2 = MAG_W'(pop_data.sq_x) + MAG_W'(pop_data.sq_y) + MAG_W'(pop_data.sq_z);
   assign is_fall = (mag2 < cfg.freefall_sq);
   assign is_loud = (mag2 > cfg.tap_sq);

   // borrow out means time ran backwards
   assign gap = {1'b0, pop_data.time_us} - {1'b0, tap_time_ff};
   assign in_window = tap_waiting_ff && !gap[TIME_W]
                      && (gap[TIME_W-1:0] >= TIME_W'(cfg.gap_min))
                      && (gap[TIME_W-1:0] <= TIME_W'(cfg.gap_max));

   assign is_double = is_loud && in_window;
   assign is_shake  = (mag2 > cfg.shake_sq) && pop_data.shake_armed
                      && (pop_data.x_jump > SAMPLE_W'(cfg.shake_half));

   assign x_ext    = (SAMPLE_W+1)'($signed(pop_data.x));
   assign y_ext    = (SAMPLE_W+1)'($signed(pop_data.y));
   assign z_ext    = (SAMPLE_W+1)'($signed(pop_data.z));
   assign tilt_pos = $signed({2'b00, cfg.tilt_level});
   assign tilt_neg = -tilt_pos;
   assign flip_neg = -$signed({1'b0, cfg.flip_level});

   always_comb begin
      if (is_fall) begin
         gesture_in = GEST_FALL;
      end else if (is_double) begin
         gesture_in = GEST_DOUBLE;
      end else if (is_shake) begin
         gesture_in = GEST_SHAKE;
      end else if (x_ext > tilt_pos) begin
         gesture_in = GEST_RIGHT;
      end else if (x_ext < tilt_neg) begin
         gesture_in = GEST_LEFT;
      end else if (y_ext > tilt_pos) begin
         gesture_in = GEST_FORWARD;
      end else if (y_ext < tilt_neg) begin
         gesture_in = GEST_BACK;
      end else if (z_ext < flip_neg) begin
         gesture_in = GEST_FLIP;
      end else begin
         gesture_in = GEST_NONE;
      end
   end

   // no tap bookkeeping on a free-fall item
   always_comb begin
      tap_time_in    = tap_time_ff;
      tap_waiting_in = tap_waiting_ff;
      if (!is_fall && is_loud) begin
         if (in_window) begin
            tap_time_in    = '0;
            tap_waiting_in = 1'b0;
         end else begin
            tap_time_in    = pop_data.time_us;
            tap_waiting_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_time_ff    <= '0;
         tap_waiting_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            tap_time_ff    <= tap_time_in;
            tap_waiting_ff <= tap_waiting_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         gesture_ff <= gesture_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gesture = gesture_ff;

endmodule

// ===== hdl/imu_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// imu_gesture_classifier
// Accelerometer gesture classifier: one gesture code per timestamped sample.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while the queue has room and gives
// one gesture code per sample, in order. A sample's code passes through the
// queue and then the output register before it is valid on the result
// channel: the front squares the three axes on the way into a two-entry
// queue, and the back sums the squares, runs the priority rules and updates
// the pending-tap state as the output register loads. Pending-tap state
// lives in the back and is read and written as the back takes a sample,
// so every sample can follow the one before. When the result channel
// stalls, the output register and the queue hold three samples, after which
// the input is held off. Write the registers only while no sample is in
// flight; a write takes effect for samples accepted from the cycle after it.
module imu_gesture_classifier
   import gc_pkg::*;
#(
   parameter int SHAKE_MIN_SAMPLES = SHAKE_MIN_SAMPLES_DEFAULT,
   parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_accel_x,
   input  logic [SAMPLE_W-1:0]   req_accel_y,
   input  logic [SAMPLE_W-1:0]   req_accel_z,
   input  logic [TIME_W-1:0]     req_time_us,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [GESTURE_W-1:0]  rsp_gesture,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   logic       push_valid;
   logic       push_ready;
   sample_type push_data;
   logic       pop_valid;
   logic       pop_ready;
   sample_type pop_data;

   gc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gc_front #(
      .SHAKE_MIN_SAMPLES (SHAKE_MIN_SAMPLES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .req_time_us (req_time_us),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   gc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   gc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_gesture (rsp_gesture)
   );

   // an accepted item is waiting in the queue on the next cycle
   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> pop_valid)
      else $error("accepted item not in queue");

   // every item taken by the back shows up on the result channel
   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> rsp_valid)
      else $error("popped item gave no result");

   // queue only refuses items while a result is held on the result channel
   a_full_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && pop_valid))
      else $error("queue full without a stall");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gesture <= GEST_FLIP))
      else $error("gesture code out of range");

endmodule

// ===== bench/imu_gesture_classifier_test.sv =====
// ----------------------------------------------------------------------------
// imu_gesture_classifier_test
// Self-checking bench for the accelerometer gesture classifier.
// ----------------------------------------------------------------------------
// A queue-fed driver offers timestamped samples and a clocked monitor predicts
// the gesture of every accepted item from its own copy of the thresholds and
// the tap, shake and sample-count state. Each gesture on the result channel is
// checked against the oldest prediction. The run walks through the reset
// thresholds, all-zero and all-max settings, an empty tap window and random
// settings, with random idling on both channels, one long result stall that
// backs the block up, and one pause on the input side until all results are in.
// ----------------------------------------------------------------------------
module imu_gesture_classifier_test;
   import gc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SHAKE_ARM   = SHAKE_MIN_SAMPLES_DEFAULT;
   localparam int HOLD_CYCLES = 150;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 10;
   localparam logic [REG_INDEX_W-1:0] NO_SUCH_REG = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
      logic signed [SAMPLE_W-1:0] z;
      logic [TIME_W-1:0]          t;
   } stim_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_accel_x = '0;
   logic [SAMPLE_W-1:0]   req_accel_y = '0;
   logic [SAMPLE_W-1:0]   req_accel_z = '0;
   logic [TIME_W-1:0]     req_time_us = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [GESTURE_W-1:0]  rsp_gesture;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   imu_gesture_classifier #(.SHAKE_MIN_SAMPLES(SHAKE_ARM)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .req_time_us (req_time_us),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_gesture (rsp_gesture),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // threshold copy, kept in step with every register write
   logic [LEVEL_W-1:0] freefall_lvl = FREEFALL_RESET;
   logic [LEVEL_W-1:0] tap_lvl      = TAP_RESET;
   logic [LEVEL_W-1:0] shake_lvl    = SHAKE_RESET;
   logic [TILT_W-1:0]  tilt_lvl     = TILT_RESET;
   logic [LEVEL_W-1:0] flip_lvl     = FLIP_RESET;
   logic [GAP_W-1:0]   gap_lo       = GAP_MIN_RESET;
   logic [GAP_W-1:0]   gap_hi       = GAP_MAX_RESET;

   // classifier state as the block should hold it
   logic [TIME_W-1:0] tap_stamp   = '0;
   bit                tap_pending = 1'b0;
   longint            last_x      = 0;
   int                seen_count  = 0;

   stim_type    pending_samples[$];
   gesture_type expected_gestures[$];
   int          queued_total = 0;
   int          accepted_total = 0;
   int          results_total = 0;
   int          fail_count = 0;
   int          settings_count = 1;
   int          gesture_hits[0:8] = '{default: 0};
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          sample_taken = 1'b0;
   bit          hold_req = 1'b0;
   bit          hold_ack = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   logic [TIME_W-1:0]          now_us = '0;
   logic signed [SAMPLE_W-1:0] last_sent_x = '0;

   function automatic gesture_type classify_sample(stim_type s);
      longint ax, ay, az, mag, ff, tp, sh, tl, fl, lo, hi, jump, gap;
      bit settled, in_window;
      gesture_type g;
      ax = signed'(s.x);
      ay = signed'(s.y);
      az = signed'(s.z);
      ff = freefall_lvl;
      tp = tap_lvl;
      sh = shake_lvl;
      tl = tilt_lvl;
      fl = flip_lvl;
      lo = gap_lo;
      hi = gap_hi;
      mag = ax * ax + ay * ay + az * az;
      g = GEST_NONE;
      settled = 1'b0;
      if (seen_count < SHAKE_ARM) seen_count++;
      if (mag < ff * ff) begin
         g = GEST_FALL;
      end else begin
         if (mag > tp * tp) begin
            in_window = 1'b0;
            // time going backwards never lands inside the window
            if (tap_pending && s.t >= tap_stamp) begin
               gap = s.t - tap_stamp;
               in_window = gap >= lo && gap <= hi;
            end
            if (in_window) begin
               tap_pending = 1'b0;
               tap_stamp = '0;
               g = GEST_DOUBLE;
               settled = 1'b1;
            end else begin
               tap_stamp = s.t;
               tap_pending = 1'b1;
            end
         end
         if (!settled && mag > sh * sh && seen_count >= SHAKE_ARM) begin
            jump = ax - last_x;
            if (jump < 0) jump = -jump;
            if (jump > sh / 2) begin
               g = GEST_SHAKE;
               settled = 1'b1;
            end
         end
         if (!settled) begin
            if (ax > tl) g = GEST_RIGHT;
            else if (ax < -tl) g = GEST_LEFT;
            else if (ay > tl) g = GEST_FORWARD;
            else if (ay < -tl) g = GEST_BACK;
            else if (az < -fl) g = GEST_FLIP;
            else g = GEST_NONE;
         end
      end
      last_x = ax;
      return g;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clip16(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_axis(int span);
      return clip16(int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic stim_type make_sample(int x, int y, int z, logic [TIME_W-1:0] t);
      stim_type s;
      s.x = 16'(x);
      s.y = 16'(y);
      s.z = 16'(z);
      s.t = t;
      return s;
   endfunction

   // mostly samples shaped around the current thresholds, some raw noise
   function automatic stim_type random_sample();
      stim_type s;
      int kind, pick, amp;
      kind = $urandom_range(99);
      if (kind < 12) begin
         s.x = rand_axis(freefall_lvl + 50);
         s.y = rand_axis(freefall_lvl + 50);
         s.z = rand_axis(freefall_lvl + 50);
      end else if (kind < 40) begin
         s.x = rand_axis(2 * tilt_lvl + 100);
         s.y = rand_axis(2 * tilt_lvl + 100);
         s.z = rand_axis(flip_lvl + 200);
      end else if (kind < 65) begin
         amp = tap_lvl + $urandom_range(400);
         s.x = rand_axis(300);
         s.y = rand_axis(300);
         s.z = $urandom_range(1) ? clip16(amp) : clip16(-amp);
      end else if (kind < 85) begin
         amp = shake_lvl / 2 + $urandom_range(shake_lvl + 1);
         s.x = (last_sent_x >= 0) ? clip16(-amp) : clip16(amp);
         s.y = rand_axis(400);
         s.z = rand_axis(400);
      end else begin
         s.x = 16'($urandom);
         s.y = 16'($urandom);
         s.z = 16'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 45 && gap_lo <= gap_hi) now_us = now_us + $urandom_range(gap_hi, gap_lo);
      else if (pick < 75) now_us = now_us + $urandom_range(2 * gap_hi + 1);
      else if (pick < 90) now_us = now_us + $urandom_range(1000);
      else if (pick < 95) now_us = now_us - $urandom_range(2 * gap_hi + 1);
      else now_us = TIME_W'({$urandom, $urandom});
      s.t = now_us;
      last_sent_x = s.x;
      return s;
   endfunction

   task automatic offer(stim_type s);
      pending_samples.push_back(s);
      queued_total++;
   endtask

   // returns at a falling edge once every queued item has its result back
   task automatic wait_drained();
      do @(negedge clock);
      while (accepted_total != queued_total || expected_gestures.size() != 0);
   endtask

   task automatic run_batch(int count);
      repeat (count) offer(random_sample());
      wait_drained();
   endtask

   task automatic csr_write(logic [REG_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_FREEFALL_LEVEL: freefall_lvl = value[LEVEL_W-1:0];
         REG_TAP_LEVEL:      tap_lvl = value[LEVEL_W-1:0];
         REG_SHAKE_LEVEL:    shake_lvl = value[LEVEL_W-1:0];
         REG_TILT_LEVEL:     tilt_lvl = value[TILT_W-1:0];
         REG_FLIP_LEVEL:     flip_lvl = value[LEVEL_W-1:0];
         REG_TAP_GAP_MIN:    gap_lo = value[GAP_W-1:0];
         REG_TAP_GAP_MAX:    gap_hi = value[GAP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(int unsigned ff, int unsigned tp, int unsigned sh,
                                int unsigned tl, int unsigned fl, int unsigned lo,
                                int unsigned hi);
      csr_write(REG_FREEFALL_LEVEL, ff);
      csr_write(REG_TAP_LEVEL, tp);
      csr_write(REG_SHAKE_LEVEL, sh);
      csr_write(REG_TILT_LEVEL, tl);
      csr_write(REG_FLIP_LEVEL, fl);
      csr_write(REG_TAP_GAP_MIN, lo);
      csr_write(REG_TAP_GAP_MAX, hi);
      settings_count++;
   endtask

   task automatic set_pace(int send_idle, int stall);
      send_idle_pct <= send_idle;
      stall_pct <= stall;
   endtask

   always @(negedge clock) begin : sample_driver
      stim_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || sample_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            s = pending_samples.pop_front();
            req_accel_x <= s.x;
            req_accel_y <= s.y;
            req_accel_z <= s.z;
            req_time_us <= s.t;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : result_receiver
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= stall_pct;
      end
   end

   always @(posedge clock) begin : gesture_monitor
      stim_type    seen;
      gesture_type want;
      sample_taken <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         seen.x = req_accel_x;
         seen.y = req_accel_y;
         seen.z = req_accel_z;
         seen.t = req_time_us;
         expected_gestures.push_back(classify_sample(seen));
         accepted_total++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_gestures.size() == 0) begin
            $error("gesture %0d arrived with no item outstanding", rsp_gesture);
            fail_count++;
         end else begin
            want = expected_gestures.pop_front();
            if (rsp_gesture !== want) begin
               $error("gesture mismatch: expected %0d, actual %0d", want, rsp_gesture);
               fail_count++;
            end
            gesture_hits[want]++;
            results_total++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned lo;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed items at the reset thresholds
      set_pace(0, 0);
      offer(make_sample(0, 0, 0, 0));
      offer(make_sample(900, 0, 0, 10));          // shake not armed yet
      offer(make_sample(199, 0, 0, 15));
      offer(make_sample(200, 0, 0, 20));          // exactly at free-fall level
      offer(make_sample(300, 0, 0, 30));          // exactly at tilt level
      offer(make_sample(301, 0, 0, 40));
      offer(make_sample(-301, 0, 0, 50));
      offer(make_sample(0, 301, 0, 60));
      offer(make_sample(0, -301, 0, 70));
      offer(make_sample(0, 0, -801, 80));
      offer(make_sample(0, 0, -800, 90));
      offer(make_sample(0, 0, 1300, 1000));
      offer(make_sample(0, 0, 1300, 100999));     // gap one below minimum
      offer(make_sample(0, 0, 1300, 200999));     // gap at minimum
      offer(make_sample(0, 0, 1300, 300000));
      offer(make_sample(0, 0, 1300, 800000));     // gap at maximum
      offer(make_sample(0, 0, 1300, 900000));
      offer(make_sample(0, 0, 1300, 1400001));    // gap one past maximum
      offer(make_sample(0, 0, 1300, 5));          // time runs backwards
      offer(make_sample(900, 0, 0, 48'hFFFF_FFFF_FFFF));
      offer(make_sample(-32768, -32768, -32768, 48'h5555_5555_5555));
      offer(make_sample(32767, 32767, 32767, 48'hAAAA_AAAA_AAAA));
      offer(make_sample(32767, -32768, 32767, 48'hAAAA_AAAA_AAAA + 200000));
      wait_drained();
      now_us = 48'd2_000_000;

      // input side pauses halfway until every result is back
      run_batch(125);
      run_batch(125);

      csr_write(NO_SUCH_REG, 32'hFFFF_FFFF);
      load_settings(0, 0, 0, 0, 0, 0, 0);
      set_pace(82, 0);
      run_batch(200);

      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF, 24'hFF_FFFF,
                    24'hFF_FFFF);
      set_pace(0, 82);
      run_batch(100);

      // tap window empty, flip level at the edge of reach
      load_settings(150, 1000, 600, 250, 32768, 300000, 100000);
      set_pace(28, 28);
      run_batch(200);

      // long result stall with the input side pushing as hard as it can
      load_settings(FREEFALL_RESET, TAP_RESET, SHAKE_RESET, TILT_RESET, FLIP_RESET,
                    GAP_MIN_RESET, GAP_MAX_RESET);
      set_pace(0, 0);
      hold_req <= ~hold_req;
      run_batch(200);

      for (int round = 0; round < 4; round++) begin
         lo = $urandom_range(400000);
         load_settings($urandom_range(400), $urandom_range(3000, 400),
                       $urandom_range(2500, 200), $urandom_range(1500),
                       $urandom_range(33000), lo, lo + $urandom_range(600000));
         case (round)
            0: set_pace(0, 0);
            1: set_pace(82, 0);
            2: set_pace(0, 82);
            default: set_pace(28, 28);
         endcase
         run_batch(200);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d samples checked under %0d threshold settings, %0d mismatches",
               results_total, settings_count, fail_count);
      $display({"gestures: none %0d fall %0d double %0d shake %0d right %0d",
                " left %0d fwd %0d back %0d flip %0d"},
               gesture_hits[0], gesture_hits[1], gesture_hits[2], gesture_hits[3],
               gesture_hits[4], gesture_hits[5], gesture_hits[6], gesture_hits[7],
               gesture_hits[8]);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
